// ----- hdl/ecal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared constants, types and the month table for the epoch-to-calendar core.
// ----------------------------------------------------------------------------
package ecal_pkg;

    localparam int SECS_W   = 32;   // non-negative seconds, sign bit stripped
    localparam int DAYS_W   = 16;   // day count, max 49710
    localparam int SOD_W    = 17;   // second of day, max 86399
    localparam int MINS_W   = 11;   // minute of day, max 1439
    localparam int WX_W     = 16;   // day count plus weekday offset
    localparam int Q7_W     = 13;   // (days + 4) / 7
    localparam int CYC_W    = 6;    // four-year cycle index
    localparam int CREM_W   = 12;   // day within a four-year cycle, before correction

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DOM_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int WDAY_W   = 3;
    localparam int YDAY_W   = 9;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 1;

    // t / 86400 estimate: (t * DAY_RECIP) >> DAY_SHIFT, low by at most one
    localparam logic [31:0] DAY_RECIP    = 32'd3257812230;
    localparam int          DAY_SHIFT    = 48;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;

    // x / 60, exact for x below 161319
    localparam logic [17:0] DIV60_RECIP = 18'd139811;
    localparam int          DIV60_SHIFT = 23;
    localparam logic [5:0]  SIXTY       = 6'd60;

    // x / 7, exact for x below 104857
    localparam logic [16:0] DIV7_RECIP = 17'd74899;
    localparam int          DIV7_SHIFT = 19;
    localparam logic [2:0]  SEVEN      = 3'd7;
    localparam logic [2:0]  EPOCH_WDAY = 3'd4;  // 1970-01-01 was a Thursday

    // four-year cycles counted from 1968-01-01 (a leap year)
    localparam logic [15:0] CYC_RECIP     = 16'd45933;
    localparam int          CYC_SHIFT     = 26;
    localparam logic [10:0] DAYS_PER_CYC  = 11'd1461;
    localparam logic [11:0] CYC_BASE_YEAR = 12'd1968;
    localparam logic [9:0]  DAYS_TO_EPOCH = 10'd731;   // 1968-01-01 .. 1970-01-01
    localparam logic [15:0] DAY_2100_MAR1 = 16'd47541; // skipped leap day
    localparam logic [11:0] YEAR_NO_LEAP  = 12'd2100;

    // first day of the second, third and fourth year of each four-year period
    localparam logic [10:0] CYC_Y1 = 11'd366;
    localparam logic [10:0] CYC_Y2 = 11'd731;
    localparam logic [10:0] CYC_Y3 = 11'd1096;

    typedef struct packed {
        logic              neg;
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
    } t_split;

    typedef struct packed {
        logic                neg;
        logic [YEAR_W-1:0]   year;
        logic                leap;
        logic [YDAY_W-1:0]   yday;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [WDAY_W-1:0]   weekday;
    } t_civil;

    // zero-based day of year on which month m0 (0 = January) starts
    function automatic logic [YDAY_W-1:0] month_start(input logic [3:0] m0, input logic leap);
        logic [YDAY_W-1:0] base;
        logic [YDAY_W-1:0] extra;
        extra = {{(YDAY_W-1){1'b0}}, leap};
        case (m0)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (m0 >= 4'd2) begin
            month_start = base + extra;
        end else begin
            month_start = base;
        end
    endfunction

endpackage

// ----- hdl/ecal_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_split
// Two stages: splits the seconds count into whole days and second of day.
// ----------------------------------------------------------------------------
module ecal_split (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [32:0]     i_secs,
    output logic            o_vld,
    output ecal_pkg::t_split o_split
);
    import ecal_pkg::*;

    logic [63:0]       w_prod;
    logic              r_vld1;
    logic              r_neg1;
    logic [SECS_W-1:0] r_t1;
    logic [DAYS_W-1:0] r_qest1;

    logic [32:0]       w_qmul;
    logic [32:0]       w_rem;
    t_split            n_split;
    t_split            r_split;
    logic              r_vld2;

    assign w_prod = 64'(i_secs[SECS_W-1:0]) * 64'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1  <= i_secs[32];
            r_t1    <= i_secs[SECS_W-1:0];
            r_qest1 <= w_prod[DAY_SHIFT +: DAYS_W];
            r_split <= n_split;
        end
    end

    // estimate is low by at most one day; fix with one compare and subtract
    assign w_qmul = 33'(r_qest1) * 33'(SECS_PER_DAY);
    assign w_rem  = {1'b0, r_t1} - w_qmul;

    always_comb begin
        n_split.neg = r_neg1;
        if (w_rem[17:0] >= 18'(SECS_PER_DAY)) begin
            n_split.days = r_qest1 + 16'd1;
            n_split.sod  = SOD_W'(w_rem[17:0] - 18'(SECS_PER_DAY));
        end else begin
            n_split.days = r_qest1;
            n_split.sod  = w_rem[SOD_W-1:0];
        end
    end

    assign o_vld   = r_vld2;
    assign o_split = r_split;

endmodule

// ----- hdl/ecal_civil.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_civil
// Three stages: time of day, weekday, year and day of year from the day count.
// ----------------------------------------------------------------------------
module ecal_civil (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  ecal_pkg::t_split i_split,
    output logic             o_vld,
    output ecal_pkg::t_civil o_civil
);
    import ecal_pkg::*;

    // stage 3
    logic [34:0]       w_mins_prod;
    logic [WX_W-1:0]   w_wx;
    logic [32:0]       w_q7_prod;
    logic              w_adj;
    logic [DAYS_W-1:0] w_dp;
    logic [31:0]       w_cyc_prod;

    logic              r_vld3;
    logic              r_neg3;
    logic [SOD_W-1:0]  r_sod3;
    logic [MINS_W-1:0] r_mins3;
    logic [WX_W-1:0]   r_wx3;
    logic [Q7_W-1:0]   r_q73;
    logic [DAYS_W-1:0] r_dp3;
    logic              r_adj3;
    logic [CYC_W-1:0]  r_qc3;

    // stage 4
    logic [SOD_W-1:0]  w_sec;
    logic [WX_W-1:0]   w_wd;
    logic [28:0]       w_hour_prod;
    logic [DAYS_W-1:0] w_cmul;
    logic [CREM_W-1:0] w_crem;
    logic [CYC_W-1:0]  n_qc4;
    logic [10:0]       n_cr4;

    logic                r_vld4;
    logic                r_neg4;
    logic [MINS_W-1:0]   r_mins4;
    logic [SECOND_W-1:0] r_sec4;
    logic [WDAY_W-1:0]   r_wd4;
    logic [HOUR_W-1:0]   r_hour4;
    logic [CYC_W-1:0]    r_qc4;
    logic [10:0]         r_cr4;
    logic                r_adj4;

    // stage 5
    logic [MINS_W-1:0] w_minute;
    logic [1:0]        w_yo;
    logic [10:0]       w_ystart;
    logic [10:0]       w_yfake;
    t_civil            n_civil;
    t_civil            r_civil;
    logic              r_vld5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_vld;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    // ---- stage 3 ----
    assign w_mins_prod = 35'(i_split.sod) * 35'(DIV60_RECIP);
    assign w_wx        = i_split.days + WX_W'(EPOCH_WDAY);
    assign w_q7_prod   = 33'(w_wx) * 33'(DIV7_RECIP);
    // pretend 2100-02-29 exists so that plain four-year cycles hold
    assign w_adj       = (i_split.days >= DAY_2100_MAR1);
    assign w_dp        = i_split.days + DAYS_W'(DAYS_TO_EPOCH) + DAYS_W'(w_adj);
    assign w_cyc_prod  = 32'(w_dp) * 32'(CYC_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg3  <= i_split.neg;
            r_sod3  <= i_split.sod;
            r_mins3 <= w_mins_prod[DIV60_SHIFT +: MINS_W];
            r_wx3   <= w_wx;
            r_q73   <= w_q7_prod[DIV7_SHIFT +: Q7_W];
            r_dp3   <= w_dp;
            r_adj3  <= w_adj;
            r_qc3   <= w_cyc_prod[CYC_SHIFT +: CYC_W];
        end
    end

    // ---- stage 4 ----
    assign w_sec       = r_sod3 - SOD_W'(r_mins3) * SOD_W'(SIXTY);
    assign w_wd        = r_wx3 - WX_W'(r_q73) * WX_W'(SEVEN);
    assign w_hour_prod = 29'(r_mins3) * 29'(DIV60_RECIP);
    assign w_cmul      = DAYS_W'(r_qc3) * DAYS_W'(DAYS_PER_CYC);
    assign w_crem      = CREM_W'(r_dp3 - w_cmul);

    always_comb begin
        if (w_crem >= CREM_W'(DAYS_PER_CYC)) begin
            n_qc4 = r_qc3 + CYC_W'(1);
            n_cr4 = 11'(w_crem - CREM_W'(DAYS_PER_CYC));
        end else begin
            n_qc4 = r_qc3;
            n_cr4 = w_crem[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg4  <= r_neg3;
            r_mins4 <= r_mins3;
            r_sec4  <= w_sec[SECOND_W-1:0];
            r_wd4   <= w_wd[WDAY_W-1:0];
            r_hour4 <= w_hour_prod[DIV60_SHIFT +: HOUR_W];
            r_qc4   <= n_qc4;
            r_cr4   <= n_cr4;
            r_adj4  <= r_adj3;
        end
    end

    // ---- stage 5 ----
    assign w_minute = r_mins4 - MINS_W'(r_hour4) * MINS_W'(SIXTY);

    always_comb begin
        if (r_cr4 >= CYC_Y3) begin
            w_yo     = 2'd3;
            w_ystart = CYC_Y3;
        end else if (r_cr4 >= CYC_Y2) begin
            w_yo     = 2'd2;
            w_ystart = CYC_Y2;
        end else if (r_cr4 >= CYC_Y1) begin
            w_yo     = 2'd1;
            w_ystart = CYC_Y1;
        end else begin
            w_yo     = 2'd0;
            w_ystart = 11'd0;
        end
        w_yfake = r_cr4 - w_ystart;

        n_civil.neg     = r_neg4;
        n_civil.year    = CYC_BASE_YEAR + YEAR_W'({r_qc4, 2'b00}) + YEAR_W'(w_yo);
        n_civil.leap    = (w_yo == 2'd0) && (n_civil.year != YEAR_NO_LEAP);
        // only 2100 itself holds the pretended leap day; later years line up again
        n_civil.yday    = YDAY_W'(w_yfake
                          - 11'(r_adj4 && (n_civil.year == YEAR_NO_LEAP)));
        n_civil.hour    = r_hour4;
        n_civil.minute  = w_minute[MINUTE_W-1:0];
        n_civil.second  = r_sec4;
        n_civil.weekday = r_wd4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_civil <= n_civil;
        end
    end

    assign o_vld   = r_vld5;
    assign o_civil = r_civil;

endmodule

// ----- hdl/ecal_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_out
// Output stage: month and day of month, invalid-input zeroing, result register.
// ----------------------------------------------------------------------------
module ecal_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  ecal_pkg::t_civil                   i_civil,
    output logic                               o_vld,
    output logic [ecal_pkg::OUT_TUSER_W-1:0]   o_user,
    output logic [ecal_pkg::OUT_TDATA_W-1:0]   o_data
);
    import ecal_pkg::*;

    logic [MONTH_W-1:0]     w_month;
    logic [YDAY_W-1:0]      w_start;
    logic [YDAY_W-1:0]      w_dom;
    logic [OUT_TDATA_W-1:0] n_data;
    logic [OUT_TUSER_W-1:0] n_user;
    logic                   r_vld;
    logic [OUT_TDATA_W-1:0] r_data;
    logic [OUT_TUSER_W-1:0] r_user;

    // month starts rise, so the last one not past yday wins
    always_comb begin
        w_month = 4'd1;
        w_start = '0;
        for (int m = 1; m < 12; m++) begin
            if (i_civil.yday >= month_start(4'(m), i_civil.leap)) begin
                w_month = 4'(m + 1);
                w_start = month_start(4'(m), i_civil.leap);
            end
        end
        w_dom = i_civil.yday - w_start + 9'd1;
    end

    always_comb begin
        if (i_civil.neg) begin
            n_data = '0;
            n_user = '0;
        end else begin
            n_data = {6'd0,
                      i_civil.yday,
                      i_civil.weekday,
                      i_civil.second,
                      i_civil.minute,
                      i_civil.hour,
                      w_dom[DOM_W-1:0],
                      w_month,
                      i_civil.year};
            n_user = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_user <= n_user;
        end
    end

    assign o_vld  = r_vld;
    assign o_user = r_user;
    assign o_data = r_data;

endmodule

// ----- hdl/epoch_seconds_to_calendar_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Seconds since 1970-01-01 00:00:00 UTC to Gregorian date, time and weekday.
//
// Input stream: one item is a 33-bit two's complement seconds count. A
// negative count gives a result with the valid flag (tuser) low and all
// fields zero.
// Output stream: one result item per input item, in order.
// Pipeline: six register stages from input accept to output valid (day
// split by reciprocal multiply, its correction, time of day, four-year
// cycle correction, year within cycle, month lookup).
// Throughput: one item per cycle unless the output stalls; every stage is
// fully pipelined; the widest unit is the 32x32 multiply of the first stage.
// Reset: synchronous, active low; clears all stage valid bits, so the
// output goes idle and the input is ready.
// Stall: when the output is valid and not taken, the whole pipeline holds and
// the input ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [32:0] epoch_seconds, [39:33] zero
    input  logic [ecal_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [40:38] weekday, [49:41] day_of_year
    output logic [ecal_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] valid_res
    output logic [ecal_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser
);
    import ecal_pkg::*;

    logic   w_en;
    logic   w_split_vld;
    t_split w_split;
    logic   w_civil_vld;
    t_civil w_civil;

    // the pipe advances unless a finished result is waiting
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    ecal_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_axis_tvalid),
        .i_secs  (i_s_axis_tdata[32:0]),
        .o_vld   (w_split_vld),
        .o_split (w_split)
    );

    ecal_civil u_civil (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_split_vld),
        .i_split (w_split),
        .o_vld   (w_civil_vld),
        .o_civil (w_civil)
    );

    ecal_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_civil_vld),
        .i_civil (w_civil),
        .o_vld   (o_m_axis_tvalid),
        .o_user  (o_m_axis_tuser),
        .o_data  (o_m_axis_tdata)
    );

endmodule

// ----- tb/calendar_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both streams of the epoch-to-calendar core, computes the calendar
// date for every accepted seconds count and compares it with the result item.
// Results must come back in order. The number of mismatches, of results still
// owed and of results checked is handed back to the testbench top.
// ----------------------------------------------------------------------------
module calendar_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_tvalid,
    input  logic                             i_in_tready,
    // [32:0] epoch_seconds, [39:33] zero
    input  logic [ecal_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                             i_out_tvalid,
    input  logic                             i_out_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [40:38] weekday, [49:41] day_of_year
    input  logic [ecal_pkg::OUT_TDATA_W-1:0] i_out_tdata,
    // [0] valid_res
    input  logic [ecal_pkg::OUT_TUSER_W-1:0] i_out_tuser,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    import ecal_pkg::*;

    typedef struct {
        logic                valid_res;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DOM_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [WDAY_W-1:0]   weekday;
        logic [YDAY_W-1:0]   day_of_year;
    } t_civil_date;

    t_civil_date expected_dates[$];
    int          fails;
    int          checked;

    function automatic bit is_leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mon,
                                                  input int unsigned yr);
        if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
            return 30;
        end else if (mon == 2) begin
            return is_leap_year(yr) ? 29 : 28;
        end
        return 31;
    endfunction

    function automatic t_civil_date civil_date_of(input logic [32:0] secs);
        t_civil_date      c;
        longint unsigned  rest;
        int unsigned      part;
        int unsigned      days;
        int unsigned      yr;
        int unsigned      ylen;
        int unsigned      mon;
        int unsigned      mlen;
        c = '{default: '0};
        // sign bit set: invalid, every field stays zero
        if (!secs[32]) begin
            rest = 64'(secs[31:0]);
            part = 32'(rest % 60);  c.second = part[SECOND_W-1:0]; rest = rest / 60;
            part = 32'(rest % 60);  c.minute = part[MINUTE_W-1:0]; rest = rest / 60;
            part = 32'(rest % 24);  c.hour   = part[HOUR_W-1:0];   rest = rest / 24;
            days = 32'(rest);
            part = (days + 4) % 7;
            c.weekday = part[WDAY_W-1:0];

            yr   = 1970;
            ylen = is_leap_year(yr) ? 366 : 365;
            while (days >= ylen) begin
                days = days - ylen;
                yr   = yr + 1;
                ylen = is_leap_year(yr) ? 366 : 365;
            end
            c.day_of_year = days[YDAY_W-1:0];

            mon  = 1;
            mlen = days_in_month(mon, yr);
            while (mon < 12 && days >= mlen) begin
                days = days - mlen;
                mon  = mon + 1;
                mlen = days_in_month(mon, yr);
            end
            c.valid_res    = 1'b1;
            c.year         = yr[YEAR_W-1:0];
            c.month        = mon[MONTH_W-1:0];
            part           = days + 1;
            c.day_of_month = part[DOM_W-1:0];
        end
        return c;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_civil_date want;
        t_civil_date got;
        if (!i_rst_n) begin
            expected_dates.delete();
            fails   = 0;
            checked = 0;
        end else begin
            // a result can never belong to the item accepted at the same edge
            if (i_out_tvalid && i_out_tready) begin
                got.valid_res    = i_out_tuser[0];
                got.year         = i_out_tdata[11:0];
                got.month        = i_out_tdata[15:12];
                got.day_of_month = i_out_tdata[20:16];
                got.hour         = i_out_tdata[25:21];
                got.minute       = i_out_tdata[31:26];
                got.second       = i_out_tdata[37:32];
                got.weekday      = i_out_tdata[40:38];
                got.day_of_year  = i_out_tdata[49:41];
                if (expected_dates.size() == 0) begin
                    $error("unexpected result item: tdata=%h tuser=%b",
                           i_out_tdata, i_out_tuser);
                    fails++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("valid_res", want.valid_res, got.valid_res);
                    check_field("year", want.year, got.year);
                    check_field("month", want.month, got.month);
                    check_field("day_of_month", want.day_of_month, got.day_of_month);
                    check_field("hour", want.hour, got.hour);
                    check_field("minute", want.minute, got.minute);
                    check_field("second", want.second, got.second);
                    check_field("weekday", want.weekday, got.weekday);
                    check_field("day_of_year", want.day_of_year, got.day_of_year);
                    checked++;
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                expected_dates.push_back(civil_date_of(i_in_tdata[32:0]));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_dates.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/tb_epoch_seconds_to_calendar_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_core
// Drives seconds counts into the epoch-to-calendar core: a directed set of
// boundary dates (leap days, year ends, the 2100 non-leap century, the top of
// the range, negative counts), then random counts in three flow-control
// phases. A long output stall makes the core back up its input. The checker
// beside the core predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_core;

    import ecal_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1440;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    int fail_count;
    int pending;
    int checked;
    int cycles;
    int snd_idle_pct;
    int rcv_idle_pct;
    int n_sent;
    int n_negative;
    logic hold_arm;
    logic rcv_hold;

    epoch_seconds_to_calendar_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    calendar_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .i_out_tuser  (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk) begin
        m_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
    end

    // long receiver hold-off so the pipeline fills and input ready drops
    initial begin
        rcv_hold = 1'b0;
        wait (hold_arm);
        @(posedge clk);
        rcv_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rcv_hold <= 1'b0;
    end

    task automatic send_seconds(input logic [32:0] secs);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-33){1'b0}}, secs};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
        if (secs[32]) n_negative++;
    endtask

    function automatic logic [32:0] random_seconds();
        int     pick;
        longint v;
        pick = $urandom_range(99);
        if (pick < 10) begin
            v = -longint'($urandom_range(32'hFFFF_FFFF, 1));
        end else if (pick < 45) begin
            v = $urandom();
        end else if (pick < 70) begin
            // straddle a midnight anywhere in the range
            v = longint'($urandom_range(49710)) * 86400 + $urandom_range(4) - 2;
        end else if (pick < 80) begin
            // around the 2100 century year, which is not a leap year
            v = 64'd4102444800 + $urandom_range(366 * 86400);
        end else if (pick < 90) begin
            v = $urandom_range(3 * 366 * 86400);
        end else begin
            v = 64'd4294967295 - $urandom_range(40 * 86400);
        end
        if (v > 64'sd4294967295) v = 64'sd4294967295;
        if (v < -64'sd4294967296) v = -64'sd4294967296;
        return v[32:0];
    endfunction

    logic [32:0] directed_secs[$] = '{
        33'd0, 33'd1, 33'd59, 33'd60, 33'd3599, 33'd3600, 33'd86399, 33'd86400,
        33'd68169600,            // 1972-02-29, first leap day
        33'd94694399,            // 1972-12-31 23:59:59, last day of a leap year
        33'd946684799,           // 1999-12-31 23:59:59
        33'd951782400,           // 2000-02-29, century leap day
        33'd978307199,           // 2000-12-31 23:59:59
        33'd2147483647, 33'd2147483648,
        33'd4102444800,          // 2100-01-01
        33'd4107542399,          // 2100-02-28 23:59:59
        33'd4107542400,          // 2100-03-01, no Feb 29 that year
        33'd4133980799,          // 2100-12-31 23:59:59
        33'd4294967295,          // top of the range
        33'h1_FFFF_FFFF,         // -1
        33'h1_0000_0000,         // most negative
        33'h1_AAAA_5555
    };

    initial begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        hold_arm     = 1'b0;
        snd_idle_pct = 16;
        rcv_idle_pct = 82;
        n_sent       = 0;
        n_negative   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_secs[i]) send_seconds(directed_secs[i]);

        // let the pipeline empty before the random part
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                snd_idle_pct = 82;
                rcv_idle_pct = 16;
            end else if (phase == 2) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
                hold_arm     = 1'b1;
            end
            for (int k = 0; k < RANDOM_ITEMS / 3; k++) send_seconds(random_seconds());
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items (%0d negative) and %0d checked results,",
                 n_sent, n_negative, checked);
        $display("spanning 1970 to 2106 with leap days, 2100 and heavy back-pressure.");
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
